### hw/rtl/ipsc_pkg.sv
// Shared types and codes for the ignition power-state controller.
// No dependencies; used by the top level and its port checker.
package ipsc_pkg;

  // Request opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SKIP = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;
  // spare code: taken and reported, changes nothing
  localparam logic [1:0] OP_RSVD = 2'd3;

  // Power state codes as shown on the result port
  localparam logic [1:0] PS_ACTIVE  = 2'd0;
  localparam logic [1:0] PS_SUMMARY = 2'd1;
  localparam logic [1:0] PS_GRACE   = 2'd2;
  localparam logic [1:0] PS_SLEEP   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_SUMMARY  = 2'd1;
  localparam logic [1:0] CFG_GRACE    = 2'd2;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [31:0] SUMMARY_RST  = 32'd30000;
  localparam logic [31:0] GRACE_RST    = 32'd3600000;

endpackage

### hw/rtl/ignition_power_state_controller.sv
// Ignition power-state controller: debounce, four-state power machine, result register.
// Depends on ipsc_pkg for opcodes, state codes and register indexes.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | in        | in_valid / in_stall  | opcode, now_ms, raw_level
//  out_    | out       | out_valid / out_stall| power_state, ignition_on, elapsed_ms,
//          |           |                      | stash_trip, clear_stash, finish_trip
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; input register, then result
// register. The state update is a single pass of subtract/compare logic between them.
// Reset (rst_n low, synchronous) empties both registers and restores the power machine
// and the timeout registers. out_stall holds the result register; the input register
// keeps taking requests while the result register is free or being drained.
module ignition_power_state_controller (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_now_ms,
  input  logic        in_raw_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_power_state,
  output logic        out_ignition_on,
  output logic [31:0] out_elapsed_ms,
  output logic        out_stash_trip,
  output logic        out_clear_stash,
  output logic        out_finish_trip,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_ACTIVE  = ipsc_pkg::PS_ACTIVE,
    ST_SUMMARY = ipsc_pkg::PS_SUMMARY,
    ST_GRACE   = ipsc_pkg::PS_GRACE,
    ST_SLEEP   = ipsc_pkg::PS_SLEEP
  } state_t;

  // configuration
  logic [15:0] debounce_hold_r;
  logic [31:0] summary_to_r;
  logic [31:0] grace_to_r;

  // input register
  logic        in_valid_r;
  logic [1:0]  opcode_r;
  logic [31:0] now_r;
  logic        lvl_r;

  // machine state
  state_t      state_r,       state_nxt;
  logic [31:0] entry_time_r,  entry_time_nxt;
  logic        skip_r,        skip_nxt;
  logic        last_lvl_r,    last_lvl_nxt;
  logic [31:0] change_time_r, change_time_nxt;
  logic        stable_r,      stable_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  ps_r;
  logic        ign_r;
  logic [31:0] elapsed_r;
  logic        stash_r, clear_r, finish_r;

  logic        stash_nxt, clear_nxt, finish_nxt;
  logic        out_load;
  logic        advance;
  logic        in_load;
  logic [31:0] held_ms;
  logic [31:0] el_ms;

  // Handshake: result register loads when empty or drained; input register advances then
  assign out_load  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_load;
  assign in_stall  = in_valid_r && !out_load;
  assign in_load   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign held_ms = now_r - change_time_r;
  assign el_ms   = now_r - entry_time_r;

  // Apply one request to the machine state
  always_comb begin
    state_nxt       = state_r;
    entry_time_nxt  = entry_time_r;
    skip_nxt        = skip_r;
    last_lvl_nxt    = last_lvl_r;
    change_time_nxt = change_time_r;
    stable_nxt      = stable_r;
    stash_nxt       = 1'b0;
    clear_nxt       = 1'b0;
    finish_nxt      = 1'b0;
    case (opcode_r)
      ipsc_pkg::OP_TICK: begin
        // debounce: a change restarts the timer, a held level commits
        if (lvl_r != last_lvl_r) begin
          last_lvl_nxt    = lvl_r;
          change_time_nxt = now_r;
        end else if (held_ms >= {16'd0, debounce_hold_r}) begin
          stable_nxt = !lvl_r;
        end
        case (state_r)
          ST_ACTIVE: begin
            if (!stable_nxt) begin
              state_nxt      = ST_SUMMARY;
              entry_time_nxt = now_r;
            end
          end
          ST_SUMMARY: begin
            if (stable_nxt) begin
              skip_nxt       = 1'b0;
              state_nxt      = ST_ACTIVE;
              entry_time_nxt = now_r;
            end else if (skip_r || el_ms >= summary_to_r) begin
              skip_nxt       = 1'b0;
              stash_nxt      = 1'b1;
              state_nxt      = ST_GRACE;
              entry_time_nxt = now_r;
            end
          end
          ST_GRACE: begin
            if (stable_nxt) begin
              clear_nxt      = 1'b1;
              state_nxt      = ST_ACTIVE;
              entry_time_nxt = now_r;
            end else if (el_ms >= grace_to_r) begin
              clear_nxt      = 1'b1;
              finish_nxt     = 1'b1;
              state_nxt      = ST_SLEEP;
              entry_time_nxt = now_r;
            end
          end
          default: ;
        endcase
      end
      ipsc_pkg::OP_SKIP: begin
        skip_nxt = 1'b1;
      end
      ipsc_pkg::OP_INIT: begin
        // sample the level and commit it at once
        last_lvl_nxt    = lvl_r;
        change_time_nxt = now_r;
        stable_nxt      = !lvl_r;
        state_nxt       = lvl_r ? ST_SLEEP : ST_ACTIVE;
        entry_time_nxt  = now_r;
      end
      default: ;
    endcase
  end

  // Hold configuration, input register, machine state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_hold_r <= ipsc_pkg::DEBOUNCE_RST;
      summary_to_r    <= ipsc_pkg::SUMMARY_RST;
      grace_to_r      <= ipsc_pkg::GRACE_RST;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      state_r         <= ST_ACTIVE;
      entry_time_r    <= '0;
      skip_r          <= 1'b0;
      last_lvl_r      <= 1'b1;
      change_time_r   <= '0;
      stable_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ipsc_pkg::CFG_DEBOUNCE: debounce_hold_r <= cfg_data[15:0];
          ipsc_pkg::CFG_SUMMARY:  summary_to_r    <= cfg_data;
          ipsc_pkg::CFG_GRACE:    grace_to_r      <= cfg_data;
          default: ;
        endcase
      end
      // advance the input register
      if (in_load) begin
        in_valid_r <= 1'b1;
        opcode_r   <= in_opcode;
        now_r      <= in_now_ms;
        lvl_r      <= in_raw_level;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      // commit the state update and capture the result
      if (advance) begin
        state_r       <= state_nxt;
        entry_time_r  <= entry_time_nxt;
        skip_r        <= skip_nxt;
        last_lvl_r    <= last_lvl_nxt;
        change_time_r <= change_time_nxt;
        stable_r      <= stable_nxt;
        ps_r          <= state_nxt;
        ign_r         <= stable_nxt;
        elapsed_r     <= now_r - entry_time_nxt;
        stash_r       <= stash_nxt;
        clear_r       <= clear_nxt;
        finish_r      <= finish_nxt;
      end
      if (out_load) begin
        out_valid_r <= advance;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_power_state = ps_r;
  assign out_ignition_on = ign_r;
  assign out_elapsed_ms  = elapsed_r;
  assign out_stash_trip  = stash_r;
  assign out_clear_stash = clear_r;
  assign out_finish_trip = finish_r;

endmodule

### hw/rtl/ipsc_checker.sv
// Port-level checker for the ignition power-state controller, bound to the top level.
// Depends on ipsc_pkg for power state codes.
module ipsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_power_state,
  input logic        out_ignition_on,
  input logic [31:0] out_elapsed_ms,
  input logic        out_stash_trip,
  input logic        out_clear_stash,
  input logic        out_finish_trip
);

  // Stash only on entry to grace, with the state clock restarted
  a_stash_enters_grace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stash_trip |->
      out_power_state == ipsc_pkg::PS_GRACE && out_elapsed_ms == 32'd0)
    else $error("stash pulse without fresh grace entry");

  // Finish comes with clear and lands in sleep pending
  a_finish_to_sleep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finish_trip |->
      out_clear_stash && out_power_state == ipsc_pkg::PS_SLEEP && !out_ignition_on)
    else $error("finish pulse without clear or sleep");

  // Clear only on leaving grace, for active or sleep pending
  a_clear_leaves_grace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clear_stash |->
      (out_power_state == ipsc_pkg::PS_ACTIVE || out_power_state == ipsc_pkg::PS_SLEEP)
      && out_elapsed_ms == 32'd0 && !out_stash_trip)
    else $error("clear pulse outside a grace exit");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_power_state) && $stable(out_elapsed_ms)
      && $stable(out_ignition_on))
    else $error("stalled result changed");

endmodule

bind ignition_power_state_controller ipsc_checker u_ipsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_power_state (out_power_state),
  .out_ignition_on (out_ignition_on),
  .out_elapsed_ms  (out_elapsed_ms),
  .out_stash_trip  (out_stash_trip),
  .out_clear_stash (out_clear_stash),
  .out_finish_trip (out_finish_trip)
);
